[hdl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants for the microprogrammed stack CPU datapath:
// memory geometry, operation codes, register indexes and the transfer payloads.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int MEM_BYTES     = 65536;
  localparam int CONTROL_WORDS = 512;

  localparam int WORD_W   = 32;
  localparam int MI_W     = 36;
  localparam int LANES    = 4;
  localparam int MEM_ROWS = MEM_BYTES / LANES;
  localparam int ROW_W    = $clog2(MEM_ROWS);
  localparam int BYTE_AW  = $clog2(MEM_BYTES);
  localparam int CS_AW    = $clog2(CONTROL_WORDS);
  localparam int NUM_REGS = 9;

  // Item operations
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_LOAD_CS  = 2'd1;
  localparam logic [1:0] OP_LOAD_MEM = 2'd2;

  // Register file slots, also the bit positions of the C mask
  localparam int R_MAR = 0;
  localparam int R_MDR = 1;
  localparam int R_PC  = 2;
  localparam int R_SP  = 3;
  localparam int R_LV  = 4;
  localparam int R_CPP = 5;
  localparam int R_TOS = 6;
  localparam int R_OPC = 7;
  localparam int R_H   = 8;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] load_address;
    logic [35:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  micro_pc;
    logic [31:0] mem_addr_reg;
    logic [31:0] mem_data_reg;
    logic [31:0] program_counter;
    logic [7:0]  fetched_byte;
    logic [31:0] stack_pointer;
    logic [31:0] local_base;
    logic [31:0] constant_pool;
    logic [31:0] top_of_stack;
    logic [31:0] old_pc;
    logic [31:0] holding;
    logic [1:0]  flags;
  } out_item_t;

  // Requests from the datapath into the byte memory
  typedef struct packed {
    logic [LANES-1:0]   wr_mask;
    logic [ROW_W-1:0]   wr_row;
    word_t              wr_data;
    logic               fetch_en;
    logic [BYTE_AW-1:0] fetch_addr;
    logic               word_en;
    logic [ROW_W-1:0]   word_row;
  } mem_req_t;

endpackage

[hdl/microprogrammed_stack_cpu_step.sv]
// ----------------------------------------------------------------------------
// microprogrammed_stack_cpu_step
// Microprogrammed stack CPU datapath: one microinstruction per tick item, with
// loads into the control store and the byte-addressed main memory.
// ----------------------------------------------------------------------------
// Flow: a tick passes the control store read, execute and finish states
//   into the output register; a load or unused operation goes straight to
//   finish. No item is taken while a tick executes; the next is taken in
//   finish, where reads return. Loads go one per cycle unless output stalls.
// Reset: registers, flags and micro address clear at once; main memory is
//   zeroed by a sweep over MEM_BYTES/4 = 16384 rows with the input stalled.
//   The control store is not cleared.
module microprogrammed_stack_cpu_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msc_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msc_pkg::out_item_t   out_data
);

  // Sequencer states
  localparam logic [1:0] ST_CLR  = 2'd0;  // memory clear sweep
  localparam logic [1:0] ST_IDLE = 2'd1;  // nothing in flight
  localparam logic [1:0] ST_EXEC = 2'd2;  // microinstruction available, execute
  localparam logic [1:0] ST_FIN  = 2'd3;  // memory data back, form the result

  // B bus sources
  localparam logic [3:0] B_MDR  = 4'd0;
  localparam logic [3:0] B_PC   = 4'd1;
  localparam logic [3:0] B_MBRU = 4'd2;
  localparam logic [3:0] B_MBR  = 4'd3;
  localparam logic [3:0] B_SP   = 4'd4;
  localparam logic [3:0] B_LV   = 4'd5;
  localparam logic [3:0] B_CPP  = 4'd6;
  localparam logic [3:0] B_TOS  = 4'd7;
  localparam logic [3:0] B_OPC  = 4'd8;

  // ALU function codes
  localparam logic [5:0] ALU_A       = 6'd24;
  localparam logic [5:0] ALU_B       = 6'd20;
  localparam logic [5:0] ALU_NOT_A   = 6'd26;
  localparam logic [5:0] ALU_NOT_B   = 6'd44;
  localparam logic [5:0] ALU_ADD     = 6'd60;
  localparam logic [5:0] ALU_ADD_INC = 6'd61;
  localparam logic [5:0] ALU_INC_A   = 6'd57;
  localparam logic [5:0] ALU_INC_B   = 6'd53;
  localparam logic [5:0] ALU_SUB     = 6'd63;
  localparam logic [5:0] ALU_DEC_B   = 6'd54;
  localparam logic [5:0] ALU_NEG_A   = 6'd59;
  localparam logic [5:0] ALU_AND     = 6'd12;
  localparam logic [5:0] ALU_OR      = 6'd28;
  localparam logic [5:0] ALU_ZERO    = 6'd16;
  localparam logic [5:0] ALU_ONE     = 6'd49;
  localparam logic [5:0] ALU_MINUS1  = 6'd50;

  // Shifter codes
  localparam logic [1:0] SH_SRA  = 2'd1;
  localparam logic [1:0] SH_SLL8 = 2'd2;

  // Jam and memory-op bit positions
  localparam int JAM_Z   = 0;
  localparam int JAM_N   = 1;
  localparam int JAM_PC  = 2;
  localparam int MO_FETCH = 0;
  localparam int MO_READ  = 1;
  localparam int MO_WRITE = 2;

  function automatic msc_pkg::word_t alu_fn(input logic [5:0] code,
                                            input msc_pkg::word_t a,
                                            input msc_pkg::word_t b,
                                            input msc_pkg::word_t keep);
    msc_pkg::word_t r;
    case (code)
      ALU_A:       r = a;
      ALU_B:       r = b;
      ALU_NOT_A:   r = ~a;
      ALU_NOT_B:   r = ~b;
      ALU_ADD:     r = a + b;
      ALU_ADD_INC: r = a + b + 32'd1;
      ALU_INC_A:   r = a + 32'd1;
      ALU_INC_B:   r = b + 32'd1;
      ALU_SUB:     r = b - a;
      ALU_DEC_B:   r = b - 32'd1;
      ALU_NEG_A:   r = 32'd0 - a;
      ALU_AND:     r = a & b;
      ALU_OR:      r = a | b;
      ALU_ZERO:    r = 32'd0;
      ALU_ONE:     r = 32'd1;
      ALU_MINUS1:  r = 32'hFFFF_FFFF;
      default:     r = keep;  // unknown code: reuse the last C bus value
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [1:0]                    state_r, state_nxt;
  logic [msc_pkg::ROW_W-1:0]     clr_row_r;
  msc_pkg::word_t                regs_r [msc_pkg::NUM_REGS];
  logic [7:0]                    mbr_r;
  logic [msc_pkg::CS_AW-1:0]     mpc_r;
  msc_pkg::word_t                cbus_r;
  logic [1:0]                    flags_r;      // bit0 Z, bit1 N

  // Carried from execute into finish
  logic                          fin_tick_r;
  logic                          fetch_pend_r;
  logic                          read_pend_r;
  logic [2:0]                    jam_r;
  logic [msc_pkg::CS_AW-1:0]     next_addr_r;

  msc_pkg::out_item_t            out_r;
  logic                          out_valid_r;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic fin_go;
  logic in_ready;
  logic in_acc;

  // Finish retires into the output register once it is free or being drained
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign in_ready = (state_r == ST_IDLE) || fin_go;
  assign in_stall = !in_ready;
  assign in_acc   = in_valid && in_ready;

  logic is_tick, is_load_cs, is_load_mem;
  logic cs_in_range, mem_in_range;
  logic [msc_pkg::BYTE_AW-1:0] load_byte_addr;

  assign is_tick      = in_data.operation == msc_pkg::OP_TICK;
  assign is_load_cs   = in_data.operation == msc_pkg::OP_LOAD_CS;
  assign is_load_mem  = in_data.operation == msc_pkg::OP_LOAD_MEM;
  assign cs_in_range  = 32'(in_data.load_address) < 32'(msc_pkg::CONTROL_WORDS);
  assign mem_in_range = 32'(in_data.load_address) < 32'(msc_pkg::MEM_BYTES);
  assign load_byte_addr = msc_pkg::BYTE_AW'(in_data.load_address);

  // --------------------------------------------------------------------------
  // Finish: fold in the memory data and form the next micro address
  // --------------------------------------------------------------------------
  logic [7:0]                mem_fetch_byte;
  msc_pkg::word_t            mem_word;
  logic [7:0]                mbr_fin;
  msc_pkg::word_t            mdr_fin;
  logic                      jam_hi;
  logic [msc_pkg::CS_AW-1:0] mpc_fin;
  logic [msc_pkg::CS_AW-1:0] mpc_now;

  assign mbr_fin = fetch_pend_r ? mem_fetch_byte : mbr_r;
  assign mdr_fin = read_pend_r ? mem_word : regs_r[msc_pkg::R_MDR];
  assign jam_hi  = (jam_r[JAM_Z] & flags_r[0]) | (jam_r[JAM_N] & flags_r[1]);
  // JMPC takes the MBR as it stands after this tick's fetch
  assign mpc_fin = next_addr_r | {jam_hi, 8'h00} | (jam_r[JAM_PC] ? {1'b0, mbr_fin} : '0);

  // A tick transferred during finish reads the control store at the new address
  assign mpc_now = ((state_r == ST_FIN) && fin_tick_r) ? mpc_fin : mpc_r;

  // --------------------------------------------------------------------------
  // Control store
  // --------------------------------------------------------------------------
  logic [msc_pkg::MI_W-1:0] mi;

  msc_ram #(
    .WIDTH(msc_pkg::MI_W),
    .DEPTH(msc_pkg::CONTROL_WORDS)
  ) u_control_store (
    .clk  (clk),
    .we   (in_acc && is_load_cs && cs_in_range),
    .waddr(msc_pkg::CS_AW'(in_data.load_address)),
    .wdata(in_data.load_data),
    .re   (in_acc && is_tick),
    .raddr(mpc_now),
    .rdata(mi)
  );

  // --------------------------------------------------------------------------
  // Execute: decode, B bus, ALU, shifter, C bus write
  // --------------------------------------------------------------------------
  logic [3:0]                bsel;
  logic [2:0]                memop;
  logic [8:0]                cmask;
  logic [7:0]                aluf;
  logic [2:0]                jam;
  logic [msc_pkg::CS_AW-1:0] next_addr;
  msc_pkg::word_t            b_val;
  msc_pkg::word_t            alu_out;
  msc_pkg::word_t            c_bus;
  logic                      flag_z, flag_n;
  msc_pkg::word_t            regs_new [msc_pkg::NUM_REGS];

  assign bsel      = mi[3:0];
  assign memop     = mi[6:4];
  assign cmask     = mi[15:7];
  assign aluf      = mi[23:16];
  assign jam       = mi[26:24];
  assign next_addr = mi[35:27];

  always_comb begin
    case (bsel)
      B_MDR:   b_val = regs_r[msc_pkg::R_MDR];
      B_PC:    b_val = regs_r[msc_pkg::R_PC];
      B_MBRU:  b_val = {24'h0, mbr_r};
      B_MBR:   b_val = {{24{mbr_r[7]}}, mbr_r};
      B_SP:    b_val = regs_r[msc_pkg::R_SP];
      B_LV:    b_val = regs_r[msc_pkg::R_LV];
      B_CPP:   b_val = regs_r[msc_pkg::R_CPP];
      B_TOS:   b_val = regs_r[msc_pkg::R_TOS];
      B_OPC:   b_val = regs_r[msc_pkg::R_OPC];
      default: b_val = 32'hFFFF_FFFF;
    endcase
  end

  assign alu_out = alu_fn(aluf[5:0], regs_r[msc_pkg::R_H], b_val, cbus_r);
  assign flag_z  = alu_out == 32'd0;
  assign flag_n  = alu_out[31];

  // Both shift bits set means no shift
  always_comb begin
    case (aluf[7:6])
      SH_SRA:  c_bus = {alu_out[31], alu_out[31:1]};
      SH_SLL8: c_bus = {alu_out[23:0], 8'h00};
      default: c_bus = alu_out;
    endcase
  end

  always_comb begin
    for (int i = 0; i < msc_pkg::NUM_REGS; i++) begin
      regs_new[i] = cmask[i] ? c_bus : regs_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Main memory requests
  // --------------------------------------------------------------------------
  msc_pkg::mem_req_t mem_req;
  logic              exec_write;

  // A read and a write in one tick write back what was just read: drop it.
  assign exec_write = (state_r == ST_EXEC) && memop[MO_WRITE] && !memop[MO_READ];

  always_comb begin
    mem_req = '0;
    if (state_r == ST_CLR) begin
      mem_req.wr_mask = '1;
      mem_req.wr_row  = clr_row_r;
      mem_req.wr_data = '0;
    end else if (exec_write) begin
      mem_req.wr_mask = '1;
      mem_req.wr_row  = regs_new[msc_pkg::R_MAR][msc_pkg::ROW_W-1:0];
      mem_req.wr_data = regs_new[msc_pkg::R_MDR];
    end else if (in_acc && is_load_mem && mem_in_range) begin
      mem_req.wr_mask = msc_pkg::LANES'(1) << load_byte_addr[1:0];
      mem_req.wr_row  = load_byte_addr[msc_pkg::BYTE_AW-1:2];
      mem_req.wr_data = {4{in_data.load_data[7:0]}};
    end
    // Reads see the memory as it was before this tick's write (read-first RAM)
    mem_req.fetch_en   = (state_r == ST_EXEC) && memop[MO_FETCH];
    mem_req.fetch_addr = regs_new[msc_pkg::R_PC][msc_pkg::BYTE_AW-1:0];
    mem_req.word_en    = (state_r == ST_EXEC) && memop[MO_READ];
    mem_req.word_row   = regs_new[msc_pkg::R_MAR][msc_pkg::ROW_W-1:0];
  end

  msc_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .fetch_byte(mem_fetch_byte),
    .word_data (mem_word)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_row_r == msc_pkg::ROW_W'(msc_pkg::MEM_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = is_tick ? ST_EXEC : ST_FIN;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          if (in_acc) begin
            state_nxt = is_tick ? ST_EXEC : ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_row_r    <= '0;
      for (int i = 0; i < msc_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      mbr_r        <= '0;
      mpc_r        <= '0;
      cbus_r       <= '0;
      flags_r      <= '0;
      fin_tick_r   <= 1'b0;
      fetch_pend_r <= 1'b0;
      read_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_row_r <= clr_row_r + msc_pkg::ROW_W'(1);
      end
      // A new item starts with no memory data pending
      if (in_acc) begin
        fin_tick_r   <= is_tick;
        fetch_pend_r <= 1'b0;
        read_pend_r  <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        for (int i = 0; i < msc_pkg::NUM_REGS; i++) begin
          regs_r[i] <= regs_new[i];
        end
        cbus_r       <= c_bus;
        flags_r      <= {flag_n, flag_z};
        fetch_pend_r <= memop[MO_FETCH];
        read_pend_r  <= memop[MO_READ];
      end
      if (fin_go) begin
        mbr_r                  <= mbr_fin;
        regs_r[msc_pkg::R_MDR] <= mdr_fin;
        if (fin_tick_r) begin
          mpc_r <= mpc_fin;
        end
      end
      // Output register: load on finish, drop once transferred
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      jam_r       <= jam;
      next_addr_r <= next_addr;
    end
    if (fin_go) begin
      out_r.micro_pc        <= fin_tick_r ? mpc_fin : mpc_r;
      out_r.mem_addr_reg    <= regs_r[msc_pkg::R_MAR];
      out_r.mem_data_reg    <= mdr_fin;
      out_r.program_counter <= regs_r[msc_pkg::R_PC];
      out_r.fetched_byte    <= mbr_fin;
      out_r.stack_pointer   <= regs_r[msc_pkg::R_SP];
      out_r.local_base      <= regs_r[msc_pkg::R_LV];
      out_r.constant_pool   <= regs_r[msc_pkg::R_CPP];
      out_r.top_of_stack    <= regs_r[msc_pkg::R_TOS];
      out_r.old_pc          <= regs_r[msc_pkg::R_OPC];
      out_r.holding         <= regs_r[msc_pkg::R_H];
      out_r.flags           <= flags_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> in_stall)
    else $error("input transfer allowed during memory clear");

  a_transfer_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == ST_IDLE || state_r == ST_FIN))
    else $error("input transfer while a tick is executing");

  a_exec_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r == ST_FIN))
    else $error("execute not followed by finish");

  a_tick_reads_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick) |=> (state_r == ST_EXEC))
    else $error("tick transfer did not move to execute");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish");

  a_no_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    exec_write |-> !(in_acc && is_load_mem))
    else $error("byte load collides with a word write");

endmodule

[hdl/msc_ram.sv]
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-port-write, single-port-read RAM with a registered,
// read-first output that holds while no read is issued.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/msc_mem.sv]
// ----------------------------------------------------------------------------
// msc_mem
// Byte-addressed main memory built from four byte lanes. Each lane is kept in
// two copies so a byte fetch and a word read can issue in the same cycle.
// ----------------------------------------------------------------------------
module msc_mem (
  input  logic              clk,
  input  msc_pkg::mem_req_t req,
  output logic [7:0]        fetch_byte,
  output msc_pkg::word_t    word_data
);

  logic [7:0] fetch_lane [msc_pkg::LANES];
  logic [7:0] word_lane  [msc_pkg::LANES];
  logic [1:0] lane_r;

  for (genvar g = 0; g < msc_pkg::LANES; g++) begin : g_lane
    msc_ram #(
      .WIDTH(8),
      .DEPTH(msc_pkg::MEM_ROWS)
    ) u_fetch_copy (
      .clk  (clk),
      .we   (req.wr_mask[g]),
      .waddr(req.wr_row),
      .wdata(req.wr_data[8*g +: 8]),
      .re   (req.fetch_en),
      .raddr(req.fetch_addr[msc_pkg::BYTE_AW-1:2]),
      .rdata(fetch_lane[g])
    );

    msc_ram #(
      .WIDTH(8),
      .DEPTH(msc_pkg::MEM_ROWS)
    ) u_word_copy (
      .clk  (clk),
      .we   (req.wr_mask[g]),
      .waddr(req.wr_row),
      .wdata(req.wr_data[8*g +: 8]),
      .re   (req.word_en),
      .raddr(req.word_row),
      .rdata(word_lane[g])
    );
  end

  // Hold the lane of the last fetch alongside the held read data
  always_ff @(posedge clk) begin
    if (req.fetch_en) begin
      lane_r <= req.fetch_addr[1:0];
    end
  end

  assign fetch_byte = fetch_lane[lane_r];
  assign word_data  = {word_lane[3], word_lane[2], word_lane[1], word_lane[0]};

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the microprogrammed stack CPU datapath. Loads,
// ticks and unused items flow through the valid/stall input channel, and an
// in-bench copy of the datapath predicts the full register snapshot that each
// transfer must return. A short hand-built microprogram comes first. Random
// microprograms then run under several idle and stall patterns, followed by
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  // Item code that the block must treat as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // B bus sources; every code from BSEL_ONES_MIN up drives all ones
  localparam logic [3:0] BSEL_MDR      = 4'd0;
  localparam logic [3:0] BSEL_PC       = 4'd1;
  localparam logic [3:0] BSEL_MBR      = 4'd2;
  localparam logic [3:0] BSEL_MBR_SX   = 4'd3;
  localparam logic [3:0] BSEL_SP       = 4'd4;
  localparam logic [3:0] BSEL_LV       = 4'd5;
  localparam logic [3:0] BSEL_CPP      = 4'd6;
  localparam logic [3:0] BSEL_TOS      = 4'd7;
  localparam logic [3:0] BSEL_OPC      = 4'd8;
  localparam logic [3:0] BSEL_ONES_MIN = 4'd9;
  localparam logic [3:0] BSEL_ONES_MAX = 4'd15;

  // ALU function codes; ALU_UNDEFINED is outside the table
  localparam logic [5:0] ALU_PASS_H    = 6'd24;
  localparam logic [5:0] ALU_PASS_B    = 6'd20;
  localparam logic [5:0] ALU_NOT_H     = 6'd26;
  localparam logic [5:0] ALU_NOT_B     = 6'd44;
  localparam logic [5:0] ALU_ADD       = 6'd60;
  localparam logic [5:0] ALU_ADD_INC   = 6'd61;
  localparam logic [5:0] ALU_INC_H     = 6'd57;
  localparam logic [5:0] ALU_INC_B     = 6'd53;
  localparam logic [5:0] ALU_SUB       = 6'd63;
  localparam logic [5:0] ALU_DEC_B     = 6'd54;
  localparam logic [5:0] ALU_NEG_H     = 6'd59;
  localparam logic [5:0] ALU_AND       = 6'd12;
  localparam logic [5:0] ALU_OR        = 6'd28;
  localparam logic [5:0] ALU_ZERO      = 6'd16;
  localparam logic [5:0] ALU_ONE       = 6'd49;
  localparam logic [5:0] ALU_MINUS_ONE = 6'd50;
  localparam logic [5:0] ALU_UNDEFINED = 6'd0;

  // Shifter control
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_SRA1 = 2'd1;
  localparam logic [1:0] SH_SLL8 = 2'd2;
  localparam logic [1:0] SH_BOTH = 2'd3;

  // Memory operation and jam bits
  localparam logic [2:0] MEM_NONE  = 3'b000;
  localparam logic [2:0] MEM_FETCH = 3'b001;
  localparam logic [2:0] MEM_READ  = 3'b010;
  localparam logic [2:0] MEM_WRITE = 3'b100;
  localparam logic [2:0] JAM_NONE  = 3'b000;
  localparam logic [2:0] JAM_Z     = 3'b001;
  localparam logic [2:0] JAM_N     = 3'b010;
  localparam logic [2:0] JAM_PC    = 3'b100;

  // C bus write masks used by the hand-built microprogram
  localparam logic [8:0] C_NONE = 9'd0;
  localparam logic [8:0] C_MDR  = 9'(1 << R_MDR);
  localparam logic [8:0] C_TOS  = 9'(1 << R_TOS);
  localparam logic [8:0] C_H    = 9'(1 << R_H);
  localparam logic [8:0] C_PTRS = 9'((1 << R_MAR) | (1 << R_PC) | (1 << R_SP) |
                                     (1 << R_LV) | (1 << R_CPP) | (1 << R_OPC));

  // The reset sweep over all MEM_BYTES/4 rows alone keeps both channels quiet for its whole run
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_PRINTED    = 100;
  localparam int PHASE_ITEMS    = 470;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  microprogrammed_stack_cpu_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow datapath state, advanced once per accepted input transfer
  logic [35:0] ctl_store [CONTROL_WORDS];
  bit          cs_loaded [CONTROL_WORDS];
  logic [7:0]  mem_image [MEM_BYTES];
  word_t       regs [NUM_REGS];
  logic [7:0]  mbr;
  logic [8:0]  upc;
  word_t       cbus_last;
  logic [1:0]  zn_flags;

  // Register snapshots still owed by the block, oldest first
  out_item_t expected_states[$];

  int mismatch_count = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow datapath
  // --------------------------------------------------------------------------
  task automatic clear_model();
    for (int i = 0; i < CONTROL_WORDS; i++) begin
      ctl_store[i] = '0;
      cs_loaded[i] = 1'b0;
    end
    for (int i = 0; i < MEM_BYTES; i++) mem_image[i] = 8'h00;
    for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
    mbr       = '0;
    upc       = '0;
    cbus_last = '0;
    zn_flags  = '0;
  endtask

  function automatic word_t b_bus_value(logic [3:0] sel);
    case (sel)
      BSEL_MDR:    return regs[R_MDR];
      BSEL_PC:     return regs[R_PC];
      BSEL_MBR:    return {24'd0, mbr};
      BSEL_MBR_SX: return {{24{mbr[7]}}, mbr};
      BSEL_SP:     return regs[R_SP];
      BSEL_LV:     return regs[R_LV];
      BSEL_CPP:    return regs[R_CPP];
      BSEL_TOS:    return regs[R_TOS];
      BSEL_OPC:    return regs[R_OPC];
      default:     return '1;
    endcase
  endfunction

  function automatic word_t alu_result(logic [5:0] code, word_t a, word_t b);
    case (code)
      ALU_PASS_H:    return a;
      ALU_PASS_B:    return b;
      ALU_NOT_H:     return ~a;
      ALU_NOT_B:     return ~b;
      ALU_ADD:       return a + b;
      ALU_ADD_INC:   return a + b + 32'd1;
      ALU_INC_H:     return a + 32'd1;
      ALU_INC_B:     return b + 32'd1;
      ALU_SUB:       return b - a;
      ALU_DEC_B:     return b - 32'd1;
      ALU_NEG_H:     return 32'd0 - a;
      ALU_AND:       return a & b;
      ALU_OR:        return a | b;
      ALU_ZERO:      return 32'd0;
      ALU_ONE:       return 32'd1;
      ALU_MINUS_ONE: return 32'hFFFF_FFFF;
      default:       return cbus_last;   // undefined code repeats the last C bus
    endcase
  endfunction

  // Apply one item to the shadow state and return the snapshot it must produce
  function automatic out_item_t step_datapath(in_item_t it);
    logic [35:0] mi;
    logic [8:0]  nxt;
    logic [2:0]  jam;
    logic [1:0]  sh;
    logic [5:0]  aluc;
    logic [8:0]  cmask;
    logic [2:0]  memop;
    logic [3:0]  bsel;
    word_t       alu_out;
    word_t       shifted;
    word_t       base;
    word_t       rd_word;
    int unsigned idx;
    out_item_t   snap;
    case (it.operation)
      OP_TICK: begin
        mi = ctl_store[upc];
        {nxt, jam, sh, aluc, cmask, memop, bsel} = mi;
        alu_out = alu_result(aluc, regs[R_H], b_bus_value(bsel));
        // flags see the ALU output before the shifter
        zn_flags = {alu_out[31], alu_out == 32'd0};
        case (sh)
          SH_SRA1: shifted = {alu_out[31], alu_out[31:1]};
          SH_SLL8: shifted = alu_out << 8;
          default: shifted = alu_out;
        endcase
        cbus_last = shifted;
        for (int i = 0; i < NUM_REGS; i++)
          if (cmask[i]) regs[i] = shifted;
        // memory ops in fixed order: fetch, word read, word write
        if ((memop & MEM_FETCH) != MEM_NONE) begin
          idx = regs[R_PC] % MEM_BYTES;
          mbr = mem_image[idx];
        end
        base = regs[R_MAR] << 2;
        if ((memop & MEM_READ) != MEM_NONE) begin
          for (int i = 0; i < 4; i++) begin
            idx = (base + i) % MEM_BYTES;
            rd_word[8*i +: 8] = mem_image[idx];
          end
          regs[R_MDR] = rd_word;
        end
        if ((memop & MEM_WRITE) != MEM_NONE) begin
          for (int i = 0; i < 4; i++) begin
            idx = (base + i) % MEM_BYTES;
            mem_image[idx] = regs[R_MDR][8*i +: 8];
          end
        end
        if ((jam & JAM_Z) != JAM_NONE) nxt[8] = nxt[8] | zn_flags[0];
        if ((jam & JAM_N) != JAM_NONE) nxt[8] = nxt[8] | zn_flags[1];
        if ((jam & JAM_PC) != JAM_NONE) nxt = nxt | {1'b0, mbr};
        upc = nxt;
      end
      OP_LOAD_CS: begin
        if (it.load_address < CONTROL_WORDS) begin
          ctl_store[it.load_address] = it.load_data;
          cs_loaded[it.load_address] = 1'b1;
        end
      end
      OP_LOAD_MEM: begin
        if (it.load_address < MEM_BYTES) mem_image[it.load_address] = it.load_data[7:0];
      end
      default: ;
    endcase
    snap.micro_pc        = upc;
    snap.mem_addr_reg    = regs[R_MAR];
    snap.mem_data_reg    = regs[R_MDR];
    snap.program_counter = regs[R_PC];
    snap.fetched_byte    = mbr;
    snap.stack_pointer   = regs[R_SP];
    snap.local_base      = regs[R_LV];
    snap.constant_pool   = regs[R_CPP];
    snap.top_of_stack    = regs[R_TOS];
    snap.old_pc          = regs[R_OPC];
    snap.holding         = regs[R_H];
    snap.flags           = zn_flags;
    return snap;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_snapshot(out_item_t got);
    out_item_t want;
    if (expected_states.size() == 0) begin
      flag_mismatch("result with nothing pending", got.micro_pc, 64'd0);
      return;
    end
    want = expected_states.pop_front();
    if (got.micro_pc !== want.micro_pc)
      flag_mismatch("micro_pc", got.micro_pc, want.micro_pc);
    if (got.mem_addr_reg !== want.mem_addr_reg)
      flag_mismatch("mem_addr_reg", got.mem_addr_reg, want.mem_addr_reg);
    if (got.mem_data_reg !== want.mem_data_reg)
      flag_mismatch("mem_data_reg", got.mem_data_reg, want.mem_data_reg);
    if (got.program_counter !== want.program_counter)
      flag_mismatch("program_counter", got.program_counter, want.program_counter);
    if (got.fetched_byte !== want.fetched_byte)
      flag_mismatch("fetched_byte", got.fetched_byte, want.fetched_byte);
    if (got.stack_pointer !== want.stack_pointer)
      flag_mismatch("stack_pointer", got.stack_pointer, want.stack_pointer);
    if (got.local_base !== want.local_base)
      flag_mismatch("local_base", got.local_base, want.local_base);
    if (got.constant_pool !== want.constant_pool)
      flag_mismatch("constant_pool", got.constant_pool, want.constant_pool);
    if (got.top_of_stack !== want.top_of_stack)
      flag_mismatch("top_of_stack", got.top_of_stack, want.top_of_stack);
    if (got.old_pc !== want.old_pc)
      flag_mismatch("old_pc", got.old_pc, want.old_pc);
    if (got.holding !== want.holding)
      flag_mismatch("holding", got.holding, want.holding);
    if (got.flags !== want.flags)
      flag_mismatch("flags", got.flags, want.flags);
  endtask

  // Sample at the edge, before this edge's nonblocking updates land
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_snapshot(out_data);
  end

  // Receiver: a requested hold-off wins over the random stall pattern
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [35:0] rand36();
    return {4'($urandom_range(15)), 32'($urandom)};
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] addr,
                                         logic [35:0] data);
    in_item_t it;
    it.operation    = op;
    it.load_address = addr;
    it.load_data    = data;
    return it;
  endfunction

  function automatic logic [35:0] microword(logic [8:0] nxt, logic [2:0] jam,
                                            logic [1:0] sh, logic [5:0] aluc,
                                            logic [8:0] cmask, logic [2:0] memop,
                                            logic [3:0] bsel);
    return {nxt, jam, sh, aluc, cmask, memop, bsel};
  endfunction

  // Mostly table ALU codes, now and then any 6-bit code
  function automatic logic [35:0] random_microword();
    logic [5:0] aluc;
    case ($urandom_range(17))
      0:  aluc = ALU_PASS_H;
      1:  aluc = ALU_PASS_B;
      2:  aluc = ALU_NOT_H;
      3:  aluc = ALU_NOT_B;
      4:  aluc = ALU_ADD;
      5:  aluc = ALU_ADD_INC;
      6:  aluc = ALU_INC_H;
      7:  aluc = ALU_INC_B;
      8:  aluc = ALU_SUB;
      9:  aluc = ALU_DEC_B;
      10: aluc = ALU_NEG_H;
      11: aluc = ALU_AND;
      12: aluc = ALU_OR;
      13: aluc = ALU_ZERO;
      14: aluc = ALU_ONE;
      15: aluc = ALU_MINUS_ONE;
      default: aluc = 6'($urandom_range(63));
    endcase
    return microword(9'($urandom_range(511)), 3'($urandom_range(7)),
                     2'($urandom_range(3)), aluc, 9'($urandom_range(511)),
                     3'($urandom_range(7)), 4'($urandom_range(15)));
  endfunction

  // Offer one item, hold it until the transfer, then record what it owes
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_states.push_back(step_datapath(it));
  endtask

  // Never tick out of an empty control store slot: fill it first
  task automatic send_tick(logic [15:0] addr, logic [35:0] data);
    if (!cs_loaded[upc]) send_item(make_item(OP_LOAD_CS, 16'(upc), random_microword()));
    send_item(make_item(OP_TICK, addr, data));
  endtask

  task automatic send_random_item();
    int          pick;
    logic [15:0] addr;
    word_t       mar_bytes;
    pick = $urandom_range(99);
    if (pick < 62) begin
      send_tick(16'($urandom), rand36());
    end else if (pick < 80) begin
      // aim memory loads near where the next fetch or word access will land
      mar_bytes = regs[R_MAR] << 2;
      case ($urandom_range(2))
        0:       addr = 16'($urandom);
        1:       addr = regs[R_PC][15:0] + 16'($urandom_range(3));
        default: addr = mar_bytes[15:0] + 16'($urandom_range(3));
      endcase
      send_item(make_item(OP_LOAD_MEM, addr, rand36()));
    end else if (pick < 96) begin
      // overwrite the live slot often enough to break self-loops
      pick = $urandom_range(99);
      if (pick < 40)      addr = 16'(upc);
      else if (pick < 80) addr = 16'($urandom_range(CONTROL_WORDS - 1));
      else                addr = 16'($urandom_range(65535, CONTROL_WORDS));
      send_item(make_item(OP_LOAD_CS, addr, random_microword()));
    end else begin
      send_item(make_item(OP_UNUSED, 16'($urandom), rand36()));
    end
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_item();
  endtask

  // Always advance at least one edge so valid never toggles twice in a step
  task automatic wait_drained();
    do @(posedge clk); while (expected_states.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-built microprogram: sign-extended MBR, arithmetic shift right,
  // shift left 8, fetch plus word read with address wrap, jump on MBR,
  // undefined ALU code with both shift bits, JAMZ/JAMN, ignored loads.
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(make_item(OP_LOAD_MEM, 16'h0000, 36'hF_FFFF_FF80));
    send_item(make_item(OP_LOAD_MEM, 16'hFFFF, 36'h0_0000_005A));
    send_item(make_item(OP_LOAD_MEM, 16'h4000, 36'h0_0000_0005));
    send_item(make_item(OP_LOAD_CS, 16'hFFFF, '1));
    send_item(make_item(OP_LOAD_CS, 16'(CONTROL_WORDS), '1));
    send_item(make_item(OP_UNUSED, '1, '1));
    send_item(make_item(OP_LOAD_CS, 16'd0,
      microword(9'd1, JAM_NONE, SH_NONE, ALU_PASS_H, C_NONE, MEM_FETCH, BSEL_MDR)));
    send_item(make_item(OP_LOAD_CS, 16'd1,
      microword(9'd2, JAM_N, SH_SRA1, ALU_PASS_B, C_TOS | C_H, MEM_NONE, BSEL_MBR_SX)));
    send_item(make_item(OP_LOAD_CS, 16'd258,
      microword(9'd3, JAM_PC, SH_SLL8, ALU_ADD, C_PTRS, MEM_FETCH | MEM_READ, BSEL_MBR)));
    send_item(make_item(OP_LOAD_CS, 16'd7,
      microword(9'd8, JAM_Z, SH_BOTH, ALU_UNDEFINED, C_MDR, MEM_WRITE, BSEL_ONES_MAX)));
    send_item(make_item(OP_LOAD_CS, 16'd8,
      microword(9'd9, JAM_Z, SH_NONE, ALU_ZERO, C_NONE, MEM_NONE, BSEL_ONES_MIN)));
    send_item(make_item(OP_LOAD_CS, 16'd265,
      microword(9'd511, JAM_NONE, SH_NONE, ALU_DEC_B, C_H, MEM_READ, BSEL_ONES_MAX)));
    send_item(make_item(OP_LOAD_CS, 16'(CONTROL_WORDS - 1), '1));
    send_tick('1, '1);
    send_tick('0, '0);
    repeat (5) send_tick(16'($urandom), rand36());
    // the all-ones word loops on itself; replace it to leave the loop
    send_item(make_item(OP_LOAD_CS, 16'(CONTROL_WORDS - 1),
      microword(9'd0, JAM_NONE, SH_NONE, ALU_NEG_H, C_H, MEM_NONE, BSEL_SP)));
    send_tick(16'($urandom), rand36());
    send_tick(16'($urandom), rand36());
  endtask

  task automatic test_full_rate();
    gap_pct   = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    gap_pct   = 64;
    stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 64;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_both_idle();
    gap_pct   = 13;
    stall_pct = 13;
    run_random(PHASE_ITEMS);
  endtask

  // Hold the result side off while items keep coming so the block backs up
  // into its input, then pause the sender until every snapshot is back.
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 300;
    run_random(40);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the memory clearing sweep stalls the first transfer; send_item waits it out
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
